FILE: design/asfp_pkg.sv
// Package for the ASCII sensor frame parser.
// Holds the frame layout constants, sample types and the offset decode function.
// Has no dependencies.
`timescale 1ns / 1ps

package asfp_pkg;

    // Frame layout
    localparam int unsigned FrameLen   = 21;
    localparam int unsigned OffW       = 5;
    localparam int unsigned AccW       = 19;
    localparam int unsigned SampleW    = 12;
    localparam int unsigned NumFields  = 4;
    localparam logic [OffW-1:0] LfOffset = OffW'(19);
    localparam logic [OffW-1:0] CrOffset = OffW'(20);
    localparam logic [OffW-1:0] EndOffset = OffW'(FrameLen);

    // Characters
    localparam logic [7:0] CharComma = 8'h2C;
    localparam logic [7:0] CharLf    = 8'h0A;
    localparam logic [7:0] CharCr    = 8'h0D;
    localparam logic signed [AccW-1:0] CharZero = AccW'(48);

    // Recentering offset for the AC fields
    localparam logic [SampleW-1:0] AcOffset = SampleW'(2048);

    typedef logic signed [AccW-1:0] acc_t;

    // Field index and character position inside the field for one offset.
    typedef struct packed {
        logic [1:0] field;
        logic [2:0] pos;
    } slot_t;

    typedef struct packed {
        logic signed [SampleW-1:0] red_ac;
        logic        [SampleW-1:0] red_dc;
        logic signed [SampleW-1:0] infrared_ac;
        logic        [SampleW-1:0] infrared_dc;
    } sample_t;

    // Split an offset into field and position (offset / 5 and offset % 5 for offsets below 20).
    function automatic slot_t decode_offset(input logic [OffW-1:0] off);
        slot_t s;
        if (off >= OffW'(15)) begin
            s.field = 2'd3;
            s.pos   = 3'(off - OffW'(15));
        end
        else if (off >= OffW'(10)) begin
            s.field = 2'd2;
            s.pos   = 3'(off - OffW'(10));
        end
        else if (off >= OffW'(5)) begin
            s.field = 2'd1;
            s.pos   = 3'(off - OffW'(5));
        end
        else begin
            s.field = 2'd0;
            s.pos   = 3'(off);
        end
        return s;
    endfunction

    // Weighted contribution of one character at a given digit position.
    function automatic acc_t digit_term(input logic [7:0] data, input logic [2:0] pos);
        acc_t d;
        acc_t term;
        d = AccW'(signed'(data)) - CharZero;
        case (pos)
            3'd0:    term = AccW'(d * AccW'(1000));
            3'd1:    term = AccW'(d * AccW'(100));
            3'd2:    term = AccW'(d * AccW'(10));
            default: term = d;
        endcase
        return term;
    endfunction

endpackage

FILE: design/ascii_sensor_frame_parser.sv
// The CR byte that closes a frame loads its sample into the result or skid register.
// Throughput: one byte per cycle while in_stall is low; each frame byte advances the offset
// and checks a separator or updates one field accumulator with a constant multiply-add.
// A two-entry output buffer (result register plus skid register) lets bytes keep flowing
// while a sample waits; input stalls only when both entries are full.
// Reset (rst_n, asynchronous, active low) clears the offset, accumulators and buffers.
`timescale 1ns / 1ps

module ascii_sensor_frame_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    input  logic                               chunk_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [asfp_pkg::SampleW-1:0] red_ac,
    output logic        [asfp_pkg::SampleW-1:0] red_dc,
    output logic signed [asfp_pkg::SampleW-1:0] infrared_ac,
    output logic        [asfp_pkg::SampleW-1:0] infrared_dc
);

    import asfp_pkg::*;

    logic [OffW-1:0] offset_reg, offset_next;
    logic            sep_ok_reg, sep_ok_next;
    acc_t            acc_reg  [NumFields];
    acc_t            acc_next [NumFields];

    sample_t out_data_reg, skid_data_reg, sample;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    sample_t out_data_next, skid_data_next;

    logic    accept, push, pop, fields_ok;
    logic [OffW-1:0] cur_off;
    logic            cur_sep_ok;
    acc_t            cur_acc [NumFields];
    slot_t           slot;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;
    assign pop      = out_valid_reg && !out_stall;

    // Chunk start clears the frame state before the byte is processed.
    always_comb
    begin
        cur_off    = chunk_start ? '0 : offset_reg;
        cur_sep_ok = chunk_start ? 1'b1 : sep_ok_reg;
        for (int i = 0; i < NumFields; i++)
        begin
            cur_acc[i] = chunk_start ? '0 : acc_reg[i];
        end
    end

    assign slot = decode_offset(cur_off);

    // Range check of the four finished fields and the recentered sample.
    always_comb
    begin
        fields_ok = 1'b1;
        for (int i = 0; i < NumFields; i++)
        begin
            if (cur_acc[i][AccW-1:SampleW] != '0)
            begin
                fields_ok = 1'b0;
            end
        end
        sample.red_ac      = signed'(cur_acc[0][SampleW-1:0] - AcOffset);
        sample.red_dc      = cur_acc[1][SampleW-1:0];
        sample.infrared_ac = signed'(cur_acc[2][SampleW-1:0] - AcOffset);
        sample.infrared_dc = cur_acc[3][SampleW-1:0];
    end

    // Per-byte frame update.
    always_comb
    begin
        offset_next = offset_reg;
        sep_ok_next = sep_ok_reg;
        for (int i = 0; i < NumFields; i++)
        begin
            acc_next[i] = acc_reg[i];
        end
        push = 1'b0;
        if (accept)
        begin
            offset_next = cur_off;
            sep_ok_next = cur_sep_ok;
            for (int i = 0; i < NumFields; i++)
            begin
                acc_next[i] = cur_acc[i];
            end
            if (cur_off < EndOffset)
            begin
                offset_next = cur_off + OffW'(1);
                if (cur_off < LfOffset && slot.pos != 3'd4)
                begin
                    acc_next[slot.field] = cur_acc[slot.field] + digit_term(data_byte, slot.pos);
                end
                else if (cur_off == LfOffset)
                begin
                    if (data_byte != CharLf)
                    begin
                        sep_ok_next = 1'b0;
                    end
                end
                else if (cur_off < LfOffset)
                begin
                    if (data_byte != CharComma)
                    begin
                        sep_ok_next = 1'b0;
                    end
                end
                else if (cur_off == CrOffset)
                begin
                    push = (data_byte == CharCr) && cur_sep_ok && fields_ok;
                end
            end
        end
    end

    // Output register with skid entry.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = sample;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = sample;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            sep_ok_reg     <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < NumFields; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            offset_reg     <= offset_next;
            sep_ok_reg     <= sep_ok_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            for (int i = 0; i < NumFields; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    // Sample payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign red_ac      = out_data_reg.red_ac;
    assign red_dc      = out_data_reg.red_dc;
    assign infrared_ac = out_data_reg.infrared_ac;
    assign infrared_dc = out_data_reg.infrared_dc;

endmodule

FILE: dv/ascii_sensor_frame_parser_test.sv
// Self-checking testbench for the ASCII sensor frame parser.
// Depends on asfp_pkg and ascii_sensor_frame_parser from the design folder.
`timescale 1ns / 1ps

module ascii_sensor_frame_parser_test;

    import asfp_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int MaxReported  = 10;
    localparam int AsciiZero    = 48;
    localparam int FieldLimit   = 4096;
    localparam int AcCenter     = 2048;
    localparam int TailCycles   = 8;

    logic clk;
    logic rst_n       = 1'b0;
    logic in_valid    = 1'b0;
    logic in_stall;
    logic [7:0] data_byte = 8'h00;
    logic chunk_start = 1'b0;
    logic out_valid;
    logic out_stall   = 1'b0;
    logic signed [SampleW-1:0] red_ac;
    logic        [SampleW-1:0] red_dc;
    logic signed [SampleW-1:0] infrared_ac;
    logic        [SampleW-1:0] infrared_dc;

    // Parser state as the testbench sees it.
    int  frame_off = 0;
    bit  frame_sep_ok = 1'b1;
    int  field_acc[NumFields];

    sample_t pending_samples[$];
    logic [7:0] chunk_bytes[$];

    int fail_count   = 0;
    int bytes_sent   = 0;
    int cycle_count  = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    ascii_sensor_frame_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .chunk_start (chunk_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_ac      (red_ac),
        .red_dc      (red_dc),
        .infrared_ac (infrared_ac),
        .infrared_dc (infrared_dc)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Random back-pressure on the sample output.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic int digit_weight(input int pos);
        case (pos)
            0:       return 1000;
            1:       return 100;
            2:       return 10;
            default: return 1;
        endcase
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MaxReported)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Advance the frame tracker by one accepted byte; queue a sample on a good CR.
    task automatic track_frame_byte(input logic [7:0] b, input logic st);
        int off;
        int fld;
        int pos;
        bit all_in_range;
        sample_t s;
        if (st)
        begin
            frame_off = 0;
            frame_sep_ok = 1'b1;
            foreach (field_acc[i]) field_acc[i] = 0;
        end
        if (frame_off >= FrameLen)
            return;
        off = frame_off;
        frame_off++;
        fld = off / 5;
        pos = off % 5;
        if (off < int'(LfOffset) && pos != 4)
        begin
            // Characters are taken as signed and are not checked to be digits.
            field_acc[fld] += (int'($signed(b)) - AsciiZero) * digit_weight(pos);
        end
        else if (off == int'(LfOffset))
        begin
            if (b != CharLf)
                frame_sep_ok = 1'b0;
        end
        else if (off < int'(LfOffset))
        begin
            if (b != CharComma)
                frame_sep_ok = 1'b0;
        end
        else
        begin
            all_in_range = 1'b1;
            foreach (field_acc[i])
                if (field_acc[i] < 0 || field_acc[i] >= FieldLimit)
                    all_in_range = 1'b0;
            if (b == CharCr && frame_sep_ok && all_in_range)
            begin
                s.red_ac      = SampleW'(field_acc[0] - AcCenter);
                s.red_dc      = SampleW'(field_acc[1]);
                s.infrared_ac = SampleW'(field_acc[2] - AcCenter);
                s.infrared_dc = SampleW'(field_acc[3]);
                pending_samples.push_back(s);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [SampleW-1:0] exp_v,
                               input logic [SampleW-1:0] act_v);
        if (act_v !== exp_v)
            report_failure($sformatf("%s expected 0x%03h (%0d) got 0x%03h (%0d)",
                name, exp_v, exp_v, act_v, act_v));
    endtask

    // Compare every accepted sample against the oldest expectation.
    always @(posedge clk)
    begin
        sample_t exp_s;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_samples.size() == 0)
                report_failure($sformatf("unexpected sample %03h %03h %03h %03h",
                    red_ac, red_dc, infrared_ac, infrared_dc));
            else
            begin
                exp_s = pending_samples.pop_front();
                check_field("red_ac", exp_s.red_ac, red_ac);
                check_field("red_dc", exp_s.red_dc, red_dc);
                check_field("infrared_ac", exp_s.infrared_ac, infrared_ac);
                check_field("infrared_dc", exp_s.infrared_dc, infrared_dc);
            end
        end
    end

    // Send one byte request; entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        chunk_start <= st;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        track_frame_byte(b, st);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_chunk(input bit with_start);
        foreach (chunk_bytes[i])
            send_byte(chunk_bytes[i], with_start && (i == 0));
    endtask

    // Hold off the sender until every queued sample has come out.
    task automatic wait_for_samples();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
    endtask

    function automatic void add_field(input int value);
        chunk_bytes.push_back(8'(AsciiZero + (value / 1000) % 10));
        chunk_bytes.push_back(8'(AsciiZero + (value / 100) % 10));
        chunk_bytes.push_back(8'(AsciiZero + (value / 10) % 10));
        chunk_bytes.push_back(8'(AsciiZero + value % 10));
    endfunction

    // Build a complete 21-byte frame from four field values.
    function automatic void build_frame(input int v0, input int v1, input int v2, input int v3);
        chunk_bytes.delete();
        add_field(v0);
        chunk_bytes.push_back(CharComma);
        add_field(v1);
        chunk_bytes.push_back(CharComma);
        add_field(v2);
        chunk_bytes.push_back(CharComma);
        add_field(v3);
        chunk_bytes.push_back(CharLf);
        chunk_bytes.push_back(CharCr);
    endfunction

    function automatic int separator_index(input int which);
        if (which < 3)
            return which * 5 + 4;
        else if (which == 3)
            return int'(LfOffset);
        return int'(CrOffset);
    endfunction

    function automatic int random_field_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return $urandom_range(0, FieldLimit - 1);
        else if (roll < 95)
            return $urandom_range(0, 9999);
        case ($urandom_range(3))
            0:       return 0;
            1:       return FieldLimit - 1;
            2:       return FieldLimit;
            default: return 9999;
        endcase
    endfunction

    function automatic void build_random_frame();
        build_frame(random_field_value(), random_field_value(),
                    random_field_value(), random_field_value());
        // Now and then a field character is replaced by an arbitrary byte.
        if ($urandom_range(9) == 0)
            chunk_bytes[$urandom_range(3) * 5 + $urandom_range(3)] = 8'($urandom_range(255));
    endfunction

    // A first chunk after reset needs no chunk_start; a repeat without it is ignored.
    task automatic test_reset_first_chunk();
        build_frame(1234, 567, 4000, 1);
        send_chunk(1'b0);
        send_chunk(1'b0);
        wait_for_samples();
    endtask

    // Field extremes: both ends of the legal range and just past it.
    task automatic test_field_extremes();
        build_frame(0, 0, 0, 0);
        send_chunk(1'b1);
        build_frame(4095, 4095, 4095, 4095);
        send_chunk(1'b1);
        build_frame(2048, 2047, 2049, 4095);
        send_chunk(1'b1);
        build_frame(4096, 0, 0, 0);
        send_chunk(1'b1);
        build_frame(0, 0, 0, 9999);
        send_chunk(1'b1);
        wait_for_samples();
    endtask

    // Non-digit characters are converted as they stand.
    task automatic test_non_digit_chars();
        build_frame(1000, 100, 0, 0);
        chunk_bytes[3]  = 8'h2F;   // "100/" gives 999
        chunk_bytes[6]  = 8'h3A;   // "0:00" gives 1000
        chunk_bytes[18] = 8'h7F;   // largest positive signed char
        send_chunk(1'b1);
        build_frame(0, 100, 0, 0);
        chunk_bytes[8]  = 8'hFF;   // negative signed char, still in range
        send_chunk(1'b1);
        build_frame(0, 0, 0, 0);
        chunk_bytes[0]  = 8'h80;   // most negative character, field rejected
        send_chunk(1'b1);
        wait_for_samples();
    endtask

    // Each comma, the LF and the CR corrupted in turn.
    task automatic test_bad_separators();
        for (int which = 0; which < 5; which++)
        begin
            build_frame(100, 200, 300, 400);
            chunk_bytes[separator_index(which)] = ~chunk_bytes[separator_index(which)];
            send_chunk(1'b1);
        end
        wait_for_samples();
    endtask

    // Short chunks, restarts in mid-frame and chunks running past 21 bytes.
    task automatic test_short_and_long_chunks();
        build_frame(11, 22, 33, 44);
        void'(chunk_bytes.pop_back());
        send_chunk(1'b1);
        build_frame(55, 66, 77, 88);
        send_chunk(1'b1);
        build_frame(99, 98, 97, 96);
        chunk_bytes.push_back(CharCr);
        chunk_bytes.push_back(CharLf);
        chunk_bytes.push_back(8'hA5);
        send_chunk(1'b1);
        build_frame(1, 2, 3, 4);
        send_chunk(1'b1);
        wait_for_samples();
    endtask

    // Mostly well-formed frames with random content, plus broken chunks and noise.
    task automatic test_random_traffic(input int byte_budget, input int send_pct,
                                       input int stall_pct);
        int stop_at;
        int kind;
        int which;
        int keep;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at)
        begin
            kind = $urandom_range(99);
            build_random_frame();
            if (kind < 70)
            begin
                // Well-formed frame, left as built.
            end
            else if (kind < 78)
            begin
                which = $urandom_range(4);
                chunk_bytes[separator_index(which)] ^= 8'($urandom_range(1, 255));
            end
            else if (kind < 86)
            begin
                keep = $urandom_range(1, FrameLen - 1);
                while (chunk_bytes.size() > keep)
                    void'(chunk_bytes.pop_back());
            end
            else if (kind < 93)
            begin
                repeat ($urandom_range(1, 5))
                    chunk_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                chunk_bytes.delete();
                repeat ($urandom_range(1, 30))
                    chunk_bytes.push_back(8'($urandom_range(255)));
            end
            if (kind >= 93)
            begin
                // Noise: chunk_start set at random on any byte.
                foreach (chunk_bytes[i])
                    send_byte(chunk_bytes[i], $urandom_range(4) == 0);
            end
            else
                send_chunk($urandom_range(19) != 0);
        end
        wait_for_samples();
    endtask

    // Test sequence.
    initial
    begin
        foreach (field_acc[i]) field_acc[i] = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_first_chunk();
        test_field_extremes();
        test_non_digit_chars();
        test_bad_separators();
        test_short_and_long_chunks();

        test_random_traffic(340, 0, 0);
        test_random_traffic(340, 87, 0);
        test_random_traffic(340, 0, 87);
        test_random_traffic(340, 16, 16);

        // Let any trailing output settle before the verdict.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TailCycles) @(negedge clk);
        if (pending_samples.size() != 0)
            report_failure($sformatf("%0d expected samples never arrived",
                pending_samples.size()));

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: ascii_sensor_frame_parser.f
design/asfp_pkg.sv
design/ascii_sensor_frame_parser.sv
dv/ascii_sensor_frame_parser_test.sv
